// ===== hw/rtl/sws_pkg.sv =====
package sws_pkg;

    localparam int HANDLE_W     = 16;
    localparam int CMD_W        = 2;
    localparam int ACT_W        = 3;
    localparam int STATE_W      = 2;
    localparam int QCNT_OUT_W   = 5;
    localparam int RETRY_LIM_W  = 8;
    localparam int RETRY_W      = 9;
    localparam int QLIM_W       = 4;
    localparam int Q_DEPTH_DEF  = 16;

    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] REG_QUEUE_LIMIT = 2'd1;
    localparam logic [1:0] REG_START_STATE = 2'd2;

    localparam logic [RETRY_LIM_W-1:0] RETRY_LIMIT_RST = 8'd3;
    localparam logic [QLIM_W-1:0]      QUEUE_LIMIT_RST = 4'd15;
    localparam logic [STATE_W-1:0]     START_STATE_RST = 2'd0;

    localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] ST_WAIT = 2'd1;
    localparam logic [STATE_W-1:0] ST_STOP = 2'd2;

    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMER = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE            = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TRANSMIT        = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ACK_RECEIVED    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP_FULL       = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STOP_NO_RETRIES = 3'd4;
    localparam logic [ACT_W-1:0] ACT_STOP_OTHER      = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DEFAULT         = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] msg_handle;
    } t_req;

    typedef struct packed {
        logic [ACT_W-1:0]      action_code;
        logic [HANDLE_W-1:0]   msg_out;
        logic [STATE_W-1:0]    state_after;
        logic [QCNT_OUT_W-1:0] queued_count;
    } t_res;

    typedef struct packed {
        logic [RETRY_LIM_W-1:0] retry_limit;
        logic [QLIM_W-1:0]      queue_limit;
    } t_cfg;

    typedef struct packed {
        logic               en;
        logic [STATE_W-1:0] value;
    } t_state_load;

    typedef struct packed {
        logic                push;
        logic                pop;
        logic [HANDLE_W-1:0] data;
    } t_q_ctl;

    function automatic logic [STATE_W-1:0] sat_state(input logic [STATE_W-1:0] v);
        return (v > ST_STOP) ? ST_STOP : v;
    endfunction

endpackage

// ===== hw/rtl/sws_queue.sv =====
module sws_queue
    import sws_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_q_ctl                             i_ctl,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count,
    output logic [HANDLE_W-1:0]                o_head_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [HANDLE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] r_head_data;
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    r_tail;
    logic [CNT_W-1:0]    r_count;
    logic [PTR_W-1:0]    n_head;
    logic [PTR_W-1:0]    n_tail;
    logic [CNT_W-1:0]    n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.pop) begin
            n_head  = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (i_ctl.push) begin
            n_tail  = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // write at tail, prefetch the entry at the next head
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_ctl.data;
        end
        if (i_ctl.push && (r_tail == n_head)) begin
            r_head_data <= i_ctl.data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_count     = r_count;
    assign o_head_data = r_head_data;

endmodule

// ===== hw/rtl/sws_fsm.sv =====
module sws_fsm
    import sws_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  t_req                               i_req,
    input  t_cfg                               i_cfg,
    input  t_state_load                        i_load,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_count,
    input  logic [HANDLE_W-1:0]                i_head_data,
    output t_q_ctl                             o_q_ctl,
    output t_res                               o_res
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > QLIM_W) ? CNT_W : QLIM_W;
    localparam int OUT_W = (CNT_W > QCNT_OUT_W) ? CNT_W : QCNT_OUT_W;

    logic [STATE_W-1:0]  r_state;
    logic [RETRY_W-1:0]  r_retry;
    logic [ACT_W-1:0]    r_action;
    logic [HANDLE_W-1:0] r_msg;
    logic [STATE_W-1:0]  n_state;
    logic [RETRY_W-1:0]  n_retry;
    logic [ACT_W-1:0]    n_action;
    logic [HANDLE_W-1:0] n_msg;
    logic [CNT_W-1:0]    n_count;
    logic [OUT_W-1:0]    count_ext;
    logic                over_limit;
    logic                room;
    logic                retry_ok;
    logic                push;
    logic                pop;

    assign over_limit = CMP_W'(i_count) > CMP_W'(i_cfg.queue_limit);
    assign room       = i_count < CNT_W'(QUEUE_DEPTH);
    assign retry_ok   = r_retry <= RETRY_W'(i_cfg.retry_limit);

    always_comb begin
        n_state  = r_state;
        n_retry  = r_retry;
        n_action = r_action;
        n_msg    = r_msg;
        push     = 1'b0;
        pop      = 1'b0;
        if (r_state == ST_IDLE && i_req.command == CMD_DATA) begin
            n_retry  = '0;
            n_action = ACT_TRANSMIT;
            n_msg    = i_req.msg_handle;
            n_state  = ST_WAIT;
        end else if (r_state == ST_WAIT && i_req.command == CMD_ACK) begin
            if (i_count == '0) begin
                n_action = ACT_ACK_RECEIVED;
                n_state  = ST_IDLE;
            end else begin
                n_retry  = '0;
                n_action = ACT_TRANSMIT;
                n_msg    = i_head_data;
                pop      = 1'b1;
            end
        end else if (r_state == ST_WAIT && i_req.command == CMD_TIMER) begin
            if (retry_ok) begin
                n_action = ACT_TRANSMIT;
                n_retry  = r_retry + 1'b1;
            end else begin
                n_action = over_limit ? ACT_STOP_FULL : ACT_STOP_NO_RETRIES;
            end
        end else if (r_state == ST_WAIT && i_req.command == CMD_DATA) begin
            if (!over_limit && room) begin
                push = 1'b1;
            end else begin
                n_action = ACT_STOP_FULL;
                n_state  = ST_STOP;
            end
        end else begin
            n_action = ACT_DEFAULT;
            n_state  = ST_IDLE;
        end
    end

    always_comb begin
        n_count = i_count;
        if (push) begin
            n_count = i_count + 1'b1;
        end else if (pop) begin
            n_count = i_count - 1'b1;
        end
    end

    assign count_ext = OUT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sat_state(START_STATE_RST);
            r_retry  <= '0;
            r_action <= ACT_NONE;
            r_msg    <= '0;
        end else if (i_load.en) begin
            r_state <= sat_state(i_load.value);
        end else if (i_fire) begin
            r_state  <= n_state;
            r_retry  <= n_retry;
            r_action <= n_action;
            r_msg    <= n_msg;
        end
    end

    assign o_q_ctl.push = push && i_fire;
    assign o_q_ctl.pop  = pop && i_fire;
    assign o_q_ctl.data = i_req.msg_handle;

    assign o_res.action_code  = n_action;
    assign o_res.msg_out      = n_msg;
    assign o_res.state_after  = n_state;
    assign o_res.queued_count = count_ext[QCNT_OUT_W-1:0];

endmodule

// ===== hw/rtl/stop_and_wait_sender_top.sv =====
// Stop-and-wait ARQ sender.
// Request channel: i_in_valid / o_in_stall / i_in_req carry one event (data, ack,
// timer or other) with a message handle. A request is taken at a clock edge with
// valid high and stall low.
// Result channel: o_out_valid / i_out_stall / o_out_res give exactly one result
// per request: held action code, current message, state and queue fill after it.
// A taken request waits in the request register; once the result register is
// free, the combinational event update between the two loads the result into it.
// While the receiver does not stall, one request is taken every cycle.
// When the receiver stalls, the result register holds; one further request may
// wait in the request register, after which o_in_stall rises.
// Configuration is through the APB port: retry limit at 0x0, queue limit at 0x4,
// start state at 0x8 (a write also reloads the state). Write only while idle.
// Reset loads the register defaults, the start state, an empty queue and no
// pending request or result; the queue store itself is not cleared.
module stop_and_wait_sender_top
    import sws_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_req                  i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_res                  o_out_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                   r_in_valid;
    t_req                   r_in;
    logic                   r_out_valid;
    t_res                   r_out;
    logic [RETRY_LIM_W-1:0] r_retry_limit;
    logic [QLIM_W-1:0]      r_queue_limit;
    logic [STATE_W-1:0]     r_start_state;
    logic                   in_take;
    logic                   out_take;
    logic                   out_free;
    logic                   fire;
    logic                   cfg_wr;
    logic [1:0]             reg_idx;
    t_cfg                   cfg;
    t_state_load            load;
    t_q_ctl                 q_ctl;
    t_res                   res;
    logic [CNT_W-1:0]       q_count;
    logic [HANDLE_W-1:0]    q_head_data;

    assign out_take   = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_req;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_LIMIT_RST;
            r_queue_limit <= QUEUE_LIMIT_RST;
            r_start_state <= START_STATE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RETRY_LIMIT: r_retry_limit <= pwdata[RETRY_LIM_W-1:0];
                REG_QUEUE_LIMIT: r_queue_limit <= pwdata[QLIM_W-1:0];
                REG_START_STATE: r_start_state <= pwdata[STATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RETRY_LIMIT: prdata = APB_DATA_W'(r_retry_limit);
            REG_QUEUE_LIMIT: prdata = APB_DATA_W'(r_queue_limit);
            REG_START_STATE: prdata = APB_DATA_W'(r_start_state);
            default:         prdata = '0;
        endcase
    end

    assign cfg.retry_limit = r_retry_limit;
    assign cfg.queue_limit = r_queue_limit;
    assign load.en         = cfg_wr && (reg_idx == REG_START_STATE);
    assign load.value      = pwdata[STATE_W-1:0];

    sws_fsm #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (r_in),
        .i_cfg       (cfg),
        .i_load      (load),
        .i_count     (q_count),
        .i_head_data (q_head_data),
        .o_q_ctl     (q_ctl),
        .o_res       (res)
    );

    sws_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (q_ctl),
        .o_count     (q_count),
        .o_head_data (q_head_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_OTHER  = 2'd3;
    localparam logic [STATE_W-1:0] ST_UNUSED  = 2'd3;
    localparam int                 FIFO_DEPTH = Q_DEPTH_DEF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_req                  i_in_req    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_res                  o_out_res;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    stop_and_wait_sender_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [RETRY_LIM_W-1:0] lim_retry = RETRY_LIMIT_RST;
    logic [QLIM_W-1:0]      lim_queue = QUEUE_LIMIT_RST;
    logic [STATE_W-1:0]     sw_state  = START_STATE_RST;
    logic [RETRY_W-1:0]     sw_retries = '0;
    logic [ACT_W-1:0]       sw_action  = ACT_NONE;
    logic [HANDLE_W-1:0]    sw_msg     = '0;
    logic [HANDLE_W-1:0]    sw_fifo [FIFO_DEPTH];
    logic [3:0]             sw_head    = '0;
    logic [3:0]             sw_tail    = '0;
    logic [QCNT_OUT_W-1:0]  sw_fill    = '0;

    t_res event_outcomes[$];
    int   fail_count  = 0;
    bit   steady_flow = 1'b0;

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [ACT_W-1:0] stop_reason();
        if (sw_fill > lim_queue)
            return ACT_STOP_FULL;
        if (sw_retries > {1'b0, lim_retry})
            return ACT_STOP_NO_RETRIES;
        return ACT_STOP_OTHER;
    endfunction

    function automatic t_res advance_sender(input t_req r);
        t_res o;
        logic hit;
        hit = 1'b1;
        if (sw_state == ST_IDLE && r.command == CMD_DATA) begin
            sw_retries = '0;
            sw_action  = ACT_TRANSMIT;
            sw_msg     = r.msg_handle;
            sw_state   = ST_WAIT;
        end else if (sw_state == ST_WAIT && r.command == CMD_ACK) begin
            if (sw_fill == 0) begin
                sw_action = ACT_ACK_RECEIVED;
                sw_state  = ST_IDLE;
            end else begin
                sw_retries = '0;
                sw_action  = ACT_TRANSMIT;
                sw_msg     = sw_fifo[sw_head];
                sw_head    = sw_head + 1'b1;
                sw_fill    = sw_fill - 1'b1;
            end
        end else if (sw_state == ST_WAIT && r.command == CMD_TIMER) begin
            if (sw_retries <= {1'b0, lim_retry}) begin
                sw_action  = ACT_TRANSMIT;
                sw_retries = sw_retries + 1'b1;
            end else begin
                sw_action = stop_reason();
            end
        end else if (sw_state == ST_WAIT && r.command == CMD_DATA) begin
            if (sw_fill <= lim_queue && sw_fill < FIFO_DEPTH) begin
                sw_fifo[sw_tail] = r.msg_handle;
                sw_tail          = sw_tail + 1'b1;
                sw_fill          = sw_fill + 1'b1;
            end else begin
                sw_action = (sw_fill > lim_queue) ? stop_reason() : ACT_STOP_FULL;
                sw_state  = ST_STOP;
            end
        end else begin
            hit = 1'b0;
        end
        if (!hit) begin
            sw_action = ACT_DEFAULT;
            sw_state  = ST_IDLE;
        end
        o.action_code  = sw_action;
        o.msg_out      = sw_msg;
        o.state_after  = sw_state;
        o.queued_count = sw_fill;
        return o;
    endfunction

    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin : result_stall
        int n;
        forever begin
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            n = steady_flow ? 0 : idle_cycles();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (event_outcomes.size() == 0) begin
                $display("%0t: result with nothing expected, got %p", $time, o_out_res);
                fail_count++;
            end else begin
                want = event_outcomes.pop_front();
                check_field("action_code", 32'(want.action_code),
                            32'(o_out_res.action_code));
                check_field("msg_out", 32'(want.msg_out), 32'(o_out_res.msg_out));
                check_field("state_after", 32'(want.state_after),
                            32'(o_out_res.state_after));
                check_field("queued_count", 32'(want.queued_count),
                            32'(o_out_res.queued_count));
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_write(input logic [1:0] idx, input int unsigned v);
        logic [31:0] mask;
        logic [31:0] word;
        logic [31:0] rd;
        case (idx)
            REG_RETRY_LIMIT: mask = 32'hFF;
            REG_QUEUE_LIMIT: mask = 32'hF;
            default:         mask = 32'h3;
        endcase
        word = ($urandom & ~mask) | (v & mask);
        apb_access(1'b1, idx, word, rd);
        case (idx)
            REG_RETRY_LIMIT: lim_retry = word[RETRY_LIM_W-1:0];
            REG_QUEUE_LIMIT: lim_queue = word[QLIM_W-1:0];
            default:         sw_state  = (word[1:0] > ST_STOP) ? ST_STOP : word[1:0];
        endcase
        if (idx != REG_START_STATE) begin
            apb_access(1'b0, idx, '0, rd);
            check_field(idx == REG_RETRY_LIMIT ? "retry_limit readback" : "queue_limit readback",
                        word & mask, rd);
        end
    endtask

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h);
        int   gap;
        t_req r;
        r.command    = cmd;
        r.msg_handle = h;
        gap = steady_flow ? 0 : idle_cycles();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        event_outcomes.push_back(advance_sender(r));
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (event_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_default_paths();
        send_request(CMD_TIMER, 16'h0001);
        send_request(CMD_ACK, 16'h0000);
        send_request(CMD_OTHER, 16'hFFFF);
        drain_requests();
    endtask

    task automatic test_retry_exhaustion();
        send_request(CMD_DATA, 16'hFFFF);
        repeat (4) send_request(CMD_TIMER, 16'h0000);
        send_request(CMD_TIMER, 16'h7FFF);
        send_request(CMD_OTHER, 16'h8000);
        drain_requests();
    endtask

    task automatic test_queue_limits();
        reg_write(REG_RETRY_LIMIT, 0);
        reg_write(REG_QUEUE_LIMIT, 0);
        send_request(CMD_DATA, 16'h0000);
        send_request(CMD_DATA, 16'h5A5A);
        send_request(CMD_DATA, 16'hA5A5);
        send_request(CMD_DATA, 16'h1234);
        send_request(CMD_DATA, 16'h8001);
        send_request(CMD_TIMER, 16'h0000);
        send_request(CMD_TIMER, 16'hFFFF);
        send_request(CMD_ACK, 16'h0000);
        send_request(CMD_ACK, 16'h0000);
        drain_requests();
    endtask

    task automatic test_start_state();
        reg_write(REG_START_STATE, 32'(ST_UNUSED));
        send_request(CMD_ACK, 16'h0F0F);
        drain_requests();
        reg_write(REG_START_STATE, 32'(ST_WAIT));
        send_request(CMD_ACK, 16'hF0F0);
        drain_requests();
        reg_write(REG_START_STATE, 32'(ST_STOP));
        send_request(CMD_DATA, 16'h00FF);
        drain_requests();
    endtask

    task automatic test_random_traffic();
        int                  phase;
        int                  k;
        int                  w_data;
        int                  roll;
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] h;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin reg_write(REG_RETRY_LIMIT, 0);   reg_write(REG_QUEUE_LIMIT, 0);  end
                1: begin reg_write(REG_RETRY_LIMIT, 255); reg_write(REG_QUEUE_LIMIT, 15); end
                3: begin reg_write(REG_RETRY_LIMIT, 1);   reg_write(REG_QUEUE_LIMIT, 15); end
                5: begin reg_write(REG_RETRY_LIMIT, 2);   reg_write(REG_QUEUE_LIMIT, 3);  end
                default: begin
                    reg_write(REG_RETRY_LIMIT, phase == 4 ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 6));
                    reg_write(REG_QUEUE_LIMIT, $urandom_range(0, 15));
                end
            endcase
            if (phase % 2 == 1)
                reg_write(REG_START_STATE, $urandom_range(0, 3));
            steady_flow = (phase == 2);
            w_data = (phase == 3) ? 60 : $urandom_range(20, 50);
            for (k = 0; k < 250; k++) begin
                roll = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0:       h = '0;
                    1:       h = '1;
                    default: h = HANDLE_W'($urandom_range(0, 65535));
                endcase
                case (sw_state)
                    ST_IDLE: cmd = (roll < 85) ? CMD_DATA : CMD_W'($urandom_range(1, 3));
                    ST_WAIT: begin
                        if (roll < w_data)
                            cmd = CMD_DATA;
                        else if (roll < 97)
                            cmd = ($urandom_range(0, 99) < 58) ? CMD_ACK : CMD_TIMER;
                        else
                            cmd = CMD_OTHER;
                    end
                    default: cmd = CMD_W'($urandom_range(0, 3));
                endcase
                send_request(cmd, h);
            end
            drain_requests();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_paths();
        test_retry_exhaustion();
        test_queue_limits();
        test_start_state();
        test_random_traffic();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("stop_and_wait_sender_top verification clean");
        else
            $display("stop_and_wait_sender_top verification failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("stop_and_wait_sender_top verification failed");
        $finish;
    end

endmodule
